/* design/wfp_pkg.sv */
package wfp_pkg;

  // default sizes
  localparam int WindowDepthDef = 64;
  localparam int CordicStepsDef = 14;

  // field and datapath widths
  localparam int RangeW     = 16;
  localparam int GainW      = 32;
  localparam int WinLenW    = 7;
  localparam int ErrW       = 18;
  localparam int DerivW     = ErrW + 1;
  localparam int OpW        = 33;
  localparam int ProdW      = 2 * OpW;
  localparam int AccW       = 64;
  localparam int CordW      = 50;
  localparam int AngW       = 33;
  localparam int TrigW      = 32;
  localparam int CordicCntW = 5;
  localparam int DivW       = 36;
  localparam int QW         = 16;

  // 2048000 = 125 << 14: drop 14 bits, then divide by 125 as a multiply by
  // ceil(2^29 / 125), exact for every dividend below 2^22
  localparam int PidShift   = 14;
  localparam int NumW       = DivW - PidShift;
  localparam int RecipShift = 29;

  // fixed-point constants, Q1.30
  localparam logic signed [OpW-1:0]   Cos45Op    = 33'sd759250125;
  localparam logic signed [CordW-1:0] InvGainQ30 = 50'sd652032874;
  localparam logic signed [TrigW-1:0] OneQ30     = 32'sd1073741824;
  localparam logic signed [AccW-1:0]  HalfQ30    = 64'sd536870912;

  // pid output scaling: q = round(S / 2048000)
  localparam logic [AccW-1:0]       PidHalf   = 64'd1024000;
  localparam logic [AccW-1:0]       SatThresh = 64'd67108864000;
  localparam logic signed [OpW-1:0] RecipOp   = 33'sd4294968;
  localparam logic [QW-1:0]         QSat      = 16'h8000;

  localparam logic signed [AccW-1:0] ErrMax = 64'sd131071;
  localparam logic signed [AccW-1:0] ErrMin = -64'sd131072;

  // speed bands
  localparam logic [QW-1:0]     BandSmall = 16'd1429;
  localparam logic [QW-1:0]     BandMid   = 16'd2859;
  localparam logic [RangeW-1:0] SpeedMid  = 16'd1000;
  localparam logic [RangeW-1:0] SpeedSlow = 16'd500;

  // register reset values
  localparam logic [RangeW-1:0]  TargetRst = 16'd1500;
  localparam logic [RangeW-1:0]  LookRst   = 16'd1000;
  localparam logic [WinLenW-1:0] WinLenRst = 7'd50;

  typedef enum logic [2:0] {
    RegKp      = 3'd0,
    RegKi      = 3'd1,
    RegKd      = 3'd2,
    RegCruise  = 3'd3,
    RegTarget  = 3'd4,
    RegLook    = 3'd5,
    RegWinLen  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic acc_en;
    logic acc_clr;
  } mac_ctrl_t;

  function automatic logic signed [AngW-1:0] atan_q30(input logic [CordicCntW-1:0] idx);
    logic signed [AngW-1:0] r;
    case (idx)
      5'd0:    r = 33'sd843314857;
      5'd1:    r = 33'sd497837829;
      5'd2:    r = 33'sd263043837;
      5'd3:    r = 33'sd133525159;
      5'd4:    r = 33'sd67021687;
      5'd5:    r = 33'sd33543516;
      5'd6:    r = 33'sd16775851;
      5'd7:    r = 33'sd8388437;
      5'd8:    r = 33'sd4194283;
      5'd9:    r = 33'sd2097149;
      5'd10:   r = 33'sd1048576;
      5'd11:   r = 33'sd524288;
      5'd12:   r = 33'sd262144;
      5'd13:   r = 33'sd131072;
      5'd14:   r = 33'sd65536;
      5'd15:   r = 33'sd32768;
      5'd16:   r = 33'sd16384;
      5'd17:   r = 33'sd8192;
      5'd18:   r = 33'sd4096;
      5'd19:   r = 33'sd2048;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* design/wfp_ram.sv */
module wfp_ram #(
  parameter int Width = 18,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [Width-1:0]     rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/wfp_mac.sv */
module wfp_mac
  import wfp_pkg::*;
(
  input  logic                   clk_i,
  input  mac_ctrl_t              ctrl_i,
  input  logic signed [OpW-1:0]  op_a_i,
  input  logic signed [OpW-1:0]  op_b_i,
  output logic signed [ProdW-1:0] prod_o,
  output logic signed [AccW-1:0] acc_o
);
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  acc_base;

  assign acc_base = ctrl_i.acc_clr ? '0 : acc_q;

  // product registered before it reaches the accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
    if (ctrl_i.acc_en) acc_q <= acc_base + AccW'(prod_q);
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

/* design/wfp_cordic.sv */
module wfp_cordic
  import wfp_pkg::*;
#(
  parameter int Steps = CordicStepsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [CordW-1:0] x0_i,
  input  logic signed [CordW-1:0] y0_i,
  output logic                    done_o,
  output logic signed [TrigW-1:0] cos_o,
  output logic signed [TrigW-1:0] sin_o
);
  typedef enum logic [1:0] {
    CIdle,
    CVec,
    CRot
  } phase_e;

  phase_e                  phase_q;
  logic [CordicCntW-1:0]   cnt_q;
  logic                    done_q;
  logic signed [CordW-1:0] x_q, y_q;
  logic signed [AngW-1:0]  z_q;

  logic signed [CordW-1:0] xs, ys, xn, yn;
  logic signed [AngW-1:0]  at, zn;
  logic                    neg, last;

  always_comb begin
    xs   = x_q >>> cnt_q;
    ys   = y_q >>> cnt_q;
    at   = atan_q30(cnt_q);
    // vectoring steers y to zero, rotation steers z to zero
    neg  = (phase_q == CVec) ? y_q[CordW-1] : !z_q[AngW-1];
    xn   = neg ? x_q - ys : x_q + ys;
    yn   = neg ? y_q + xs : y_q - xs;
    zn   = neg ? z_q - at : z_q + at;
    last = (cnt_q == CordicCntW'(Steps - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= CIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        CIdle: begin
          if (start_i) begin
            x_q     <= x0_i;
            y_q     <= y0_i;
            z_q     <= '0;
            cnt_q   <= '0;
            phase_q <= CVec;
          end
        end
        CVec: begin
          z_q <= zn;
          if (last) begin
            x_q     <= InvGainQ30;
            y_q     <= '0;
            cnt_q   <= '0;
            phase_q <= CRot;
          end else begin
            x_q   <= xn;
            y_q   <= yn;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        CRot: begin
          x_q <= xn;
          y_q <= yn;
          z_q <= zn;
          if (last) begin
            phase_q <= CIdle;
            done_q  <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: phase_q <= CIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign cos_o  = x_q[TrigW-1:0];
  assign sin_o  = y_q[TrigW-1:0];

endmodule

/* design/wall_follow_pid_steering.sv */
// flow: one beat at a time; in_stall_o is high from the accepted input beat until the
//   result is loaded, and a result still held by the receiver adds its stall
// at the default step count the cordic vectoring and rotation loop takes most of that time;
//   it is skipped when the side range is zero, and the next beat is taken the cycle after the result is loaded
// reset: asynchronous active low; gains and cruise speed zero, target 1500, lookahead 1000,
//   window length 50, window empty, last error zero
module wall_follow_pid_steering
  import wfp_pkg::*;
#(
  parameter int WINDOW_DEPTH = WindowDepthDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [GainW-1:0]         cfg_data_i,
  // input beats
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [RangeW-1:0]        range_side_i,
  input  logic [RangeW-1:0]        range_ahead_i,
  // result beats
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [QW-1:0]     steering_angle_o,
  output logic [RangeW-1:0]        drive_speed_o
);
  localparam int PtrW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int IdxW  = PtrW + 1;
  localparam int FillW = $clog2(WINDOW_DEPTH + 1);
  localparam int SumW  = ErrW + $clog2(WINDOW_DEPTH);
  localparam int LenW  = (FillW > WinLenW) ? FillW : WinLenW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VMUL,
    S_VLD,
    S_VRUN,
    S_PRED0,
    S_PRED1,
    S_PRED2,
    S_ERR,
    S_PID0,
    S_PID1,
    S_PID2,
    S_PID3,
    S_DIV0,
    S_DIV,
    S_QUOT,
    S_DONE
  } state_e;

  // configuration registers
  logic signed [GainW-1:0] kp_q, ki_q, kd_q;
  logic [RangeW-1:0]       cruise_q, target_q, look_q;
  logic [WinLenW-1:0]      winlen_q;

  // window bookkeeping
  logic [FillW-1:0]        fill_q;
  logic [PtrW-1:0]         ptr_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [ErrW-1:0]  last_q;

  // sequencer and outputs
  state_e                  state_q;
  logic                    out_valid_q;
  logic signed [QW-1:0]    steer_q;
  logic [RangeW-1:0]       speed_q;

  // item datapath
  logic [RangeW-1:0]       a_q, b_q;
  logic signed [TrigW-1:0] c_q, s_q;
  logic signed [ErrW-1:0]  e_q;
  logic signed [DerivW-1:0] d_q;
  logic [NumW-1:0]         n_q;
  logic                    sat_q;
  logic [QW-1:0]           q_q;
  logic                    neg_q;

  logic                    in_acc, out_acc, cfg_winlen;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign cfg_winlen = cfg_we_i && (cfg_idx_i == RegWinLen);
  assign in_stall_o = (state_q != S_IDLE);

  // ---------------------------------------------------------------------------------------
  // configuration writes, to be made only while idle; the block itself does not enforce it
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      cruise_q <= '0;
      target_q <= TargetRst;
      look_q   <= LookRst;
      winlen_q <= WinLenRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegKp:     kp_q     <= cfg_data_i;
        RegKi:     ki_q     <= cfg_data_i;
        RegKd:     kd_q     <= cfg_data_i;
        RegCruise: cruise_q <= cfg_data_i[RangeW-1:0];
        RegTarget: target_q <= cfg_data_i[RangeW-1:0];
        RegLook:   look_q   <= cfg_data_i[RangeW-1:0];
        RegWinLen: winlen_q <= cfg_data_i[WinLenW-1:0];
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // error window: effective length and index of the oldest entry
  // ---------------------------------------------------------------------------------------
  logic [LenW-1:0]        wl_ext, len_eff;
  logic                   win_full;
  logic [IdxW-1:0]        ptr_ext, fill_ext, old_ext;
  logic [PtrW-1:0]        old_idx, ptr_nxt;
  logic [ErrW-1:0]        old_raw;

  always_comb begin
    wl_ext = LenW'(winlen_q);
    // zero counts as one, anything past the store depth as the full store
    if (wl_ext == '0)                         len_eff = LenW'(1);
    else if (wl_ext > LenW'(WINDOW_DEPTH))    len_eff = LenW'(WINDOW_DEPTH);
    else                                      len_eff = wl_ext;
    win_full = (LenW'(fill_q) >= len_eff);
    ptr_ext  = IdxW'(ptr_q);
    fill_ext = IdxW'(fill_q);
    old_ext  = (ptr_ext >= fill_ext) ? ptr_ext - fill_ext
                                     : ptr_ext + IdxW'(WINDOW_DEPTH) - fill_ext;
    old_idx  = old_ext[PtrW-1:0];
    ptr_nxt  = (ptr_q == PtrW'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  end

  // ---------------------------------------------------------------------------------------
  // shared multiply-accumulate unit and cordic
  // ---------------------------------------------------------------------------------------
  mac_ctrl_t                mac_ctrl;
  logic signed [OpW-1:0]    op_a, op_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [AccW-1:0]   acc;

  always_comb begin
    op_a     = '0;
    op_b     = '0;
    mac_ctrl = '0;
    unique case (state_q)
      S_VMUL: begin
        op_a = $signed({{(OpW-RangeW){1'b0}}, a_q});
        op_b = Cos45Op;
      end
      S_PRED0: begin
        op_a = $signed({{(OpW-RangeW){1'b0}}, b_q});
        op_b = OpW'(c_q);
      end
      S_PRED1: begin
        op_a     = $signed({{(OpW-RangeW){1'b0}}, look_q});
        op_b     = OpW'(s_q);
        mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b1};
      end
      S_PRED2: mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b0};
      S_PID0: begin
        op_a = OpW'(kp_q);
        op_b = OpW'(e_q);
      end
      S_PID1: begin
        op_a     = OpW'(ki_q);
        op_b     = OpW'(sum_q);
        mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b1};
      end
      S_PID2: begin
        op_a     = OpW'(kd_q);
        op_b     = OpW'(d_q);
        mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b0};
      end
      S_PID3: mac_ctrl = '{acc_en: 1'b1, acc_clr: 1'b0};
      // divide by 125 through the reciprocal
      S_DIV: begin
        op_a = $signed({{(OpW-NumW){1'b0}}, n_q});
        op_b = RecipOp;
      end
      default: ;
    endcase
  end

  wfp_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  logic                    cor_start, cor_done;
  logic signed [CordW-1:0] cor_x0, cor_y0;
  logic signed [TrigW-1:0] cor_cos, cor_sin;

  // x = a*cos45, y = x - b, both scaled by 2^30
  assign cor_start = (state_q == S_VLD);
  assign cor_x0    = CordW'(prod);
  assign cor_y0    = cor_x0 - ($signed({{(CordW-RangeW){1'b0}}, b_q}) <<< 30);

  wfp_cordic #(
    .Steps (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .x0_i    (cor_x0),
    .y0_i    (cor_y0),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  logic [ErrW-1:0] ram_wdata;

  wfp_ram #(
    .Width (ErrW),
    .Depth (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (state_q == S_ERR),
    .waddr_i (ptr_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (old_idx),
    .rdata_o (old_raw)
  );

  // ---------------------------------------------------------------------------------------
  // error, window sum, derivative
  // ---------------------------------------------------------------------------------------
  logic signed [AccW-1:0]   pred, err_w;
  logic signed [ErrW-1:0]   err;
  logic signed [SumW-1:0]   sum_nxt;
  logic signed [DerivW-1:0] deriv;

  always_comb begin
    pred  = (acc + HalfQ30) >>> 30;
    err_w = $signed({{(AccW-RangeW){1'b0}}, target_q}) - pred;
    if (err_w > ErrMax)      err = ErrW'(ErrMax);
    else if (err_w < ErrMin) err = ErrW'(ErrMin);
    else                     err = ErrW'(err_w);
    sum_nxt = sum_q - (win_full ? SumW'($signed(old_raw)) : SumW'(0)) + SumW'(err);
    // no derivative on the first item after a zero error
    deriv   = (last_q == '0) ? '0 : DerivW'(last_q) - DerivW'(err);
  end

  assign ram_wdata = err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ptr_q  <= '0;
      sum_q  <= '0;
      last_q <= '0;
    end else if (cfg_winlen) begin
      fill_q <= '0;
      ptr_q  <= '0;
      sum_q  <= '0;
    end else if (state_q == S_ERR) begin
      if (!win_full) fill_q <= fill_q + 1'b1;
      ptr_q  <= ptr_nxt;
      sum_q  <= sum_nxt;
      last_q <= err;
    end
  end

  // ---------------------------------------------------------------------------------------
  // rounding divide by 2048000, magnitude only, clipped at 32768
  // ---------------------------------------------------------------------------------------
  logic [AccW-1:0] mag, mag_rnd;

  always_comb begin
    mag     = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
    mag_rnd = mag + PidHalf;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          a_q <= range_side_i;
          b_q <= range_ahead_i;
          // side beam on the car: wall taken as straight ahead or nothing seen
          c_q <= (range_ahead_i == '0) ? OneQ30 : '0;
          s_q <= (range_ahead_i == '0) ? '0 : -OneQ30;
        end
      end
      S_VRUN: begin
        if (cor_done) begin
          c_q <= cor_cos;
          s_q <= cor_sin;
        end
      end
      S_ERR: begin
        e_q <= err;
        d_q <= deriv;
      end
      S_DIV0: begin
        neg_q <= acc[AccW-1];
        sat_q <= (mag_rnd >= SatThresh);
        n_q   <= mag_rnd[DivW-1:PidShift];
      end
      S_QUOT: q_q <= sat_q ? QSat : prod[RecipShift +: QW];
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // result formatting
  // ---------------------------------------------------------------------------------------
  logic signed [QW-1:0] steer_nxt;
  logic [RangeW-1:0]    speed_nxt;

  always_comb begin
    // steering is the negated pid sum, clipped to the q3.13 range
    if (neg_q) steer_nxt = q_q[QW-1] ? $signed({1'b0, {(QW-1){1'b1}}}) : $signed(q_q);
    else       steer_nxt = $signed(~q_q + 1'b1);
    priority if (q_q <= BandSmall) speed_nxt = cruise_q;
    else if (q_q <= BandMid)       speed_nxt = SpeedMid;
    else                           speed_nxt = SpeedSlow;
  end

  // ---------------------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      steer_q     <= '0;
      speed_q     <= '0;
    end else begin
      // a finished result reloads the register in the same cycle
      if (out_acc && (state_q != S_DONE)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) state_q <= (range_side_i == '0) ? S_PRED0 : S_VMUL;
        end
        S_VMUL:  state_q <= S_VLD;
        S_VLD:   state_q <= S_VRUN;
        S_VRUN:  if (cor_done) state_q <= S_PRED0;
        S_PRED0: state_q <= S_PRED1;
        S_PRED1: state_q <= S_PRED2;
        S_PRED2: state_q <= S_ERR;
        S_ERR:   state_q <= S_PID0;
        S_PID0:  state_q <= S_PID1;
        S_PID1:  state_q <= S_PID2;
        S_PID2:  state_q <= S_PID3;
        S_PID3:  state_q <= S_DIV0;
        S_DIV0:  state_q <= S_DIV;
        S_DIV:   state_q <= S_QUOT;
        S_QUOT:  state_q <= S_DONE;
        S_DONE: begin
          // output register free or being emptied this cycle
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            steer_q     <= steer_nxt;
            speed_q     <= speed_nxt;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign steering_angle_o = steer_q;
  assign drive_speed_o    = speed_q;

  // ---------------------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WINDOW_DEPTH))
    else $error("window fill past store depth");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("sequencer idle right after an input beat");

  a_cordic_done_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == S_VRUN))
    else $error("cordic finished outside its wait state");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && !(out_valid_q && out_stall_i) |=> out_valid_q && (state_q == S_IDLE))
    else $error("finished result not loaded");

endmodule

/* tb/sv/wfp_steering_checker.sv */
module wfp_steering_checker
  import wfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [GainW-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [RangeW-1:0] range_side_i,
  input  logic [RangeW-1:0] range_ahead_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [QW-1:0]     steering_angle_i,
  input  logic [RangeW-1:0] drive_speed_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int Depth = 64;
  localparam int Steps = 14;

  typedef struct packed {
    logic [15:0] steer;
    logic [15:0] speed;
  } steer_cmd_t;

  longint arctan_q30 [20] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048};

  // predictor copy of registers and pid state
  longint     kp, ki, kd;
  longint     cruise, target, lookahead;
  int         win_len;
  longint     err_hist [Depth];
  int         fill, wptr;
  longint     err_sum, prev_err;
  steer_cmd_t cmd_q [$];

  function automatic longint wall_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x -= ys; y += xs; z -= arctan_q30[i];
      end else begin
        x += ys; y -= xs; z += arctan_q30[i];
      end
    end
    return z;
  endfunction

  task automatic rotate_unit(input longint z, output longint c, output longint s);
    longint x, y, xs, ys;
    x = 652032874;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_q30[i];
      end else begin
        x += ys; y -= xs; z += arctan_q30[i];
      end
    end
    c = x;
    s = y;
  endtask

  task automatic predict_steering(input longint a, input longint b);
    longint c, s, x, pred_dist, e, d, total, mag, q;
    int len, old;
    steer_cmd_t r;
    if (a == 0) begin
      c = (b == 0) ? 64'sd1073741824 : 0;
      s = (b > 0) ? -64'sd1073741824 : 0;
    end else begin
      x = a * 759250125;
      rotate_unit(wall_angle(x, x - b * 1073741824), c, s);
    end
    pred_dist = (b * c + lookahead * s + 536870912) >>> 30;
    e = target - pred_dist;
    if (e > 131071) e = 131071;
    if (e < -131072) e = -131072;
    len = (win_len == 0) ? 1 : (win_len > Depth ? Depth : win_len);
    if (fill >= len) begin
      old = (wptr + Depth - (fill % (Depth + 1))) % Depth;
      err_sum -= err_hist[old];
    end else begin
      fill++;
    end
    err_hist[wptr] = e;
    wptr = (wptr + 1) % Depth;
    err_sum += e;
    d = (prev_err == 0) ? 0 : prev_err - e;
    prev_err = e;
    total = kp * e + ki * err_sum + kd * d;
    mag = (total < 0) ? -total : total;
    mag = (mag + 1024000) / 2048000;
    q = (total < 0) ? mag : -mag;   // already negated
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    r.steer = q[15:0];
    r.speed = (mag <= 1429) ? cruise[15:0] : (mag <= 2859) ? 16'd1000 : 16'd500;
    cmd_q = {cmd_q, r};
  endtask

  assign pending_o = cmd_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    steer_cmd_t want;
    if (!rst_ni) begin
      kp = 0; ki = 0; kd = 0; cruise = 0; target = 1500; lookahead = 1000;
      win_len = 50; fill = 0; wptr = 0; err_sum = 0; prev_err = 0;
      cmd_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          RegKp:     kp = longint'($signed(cfg_data_i));
          RegKi:     ki = longint'($signed(cfg_data_i));
          RegKd:     kd = longint'($signed(cfg_data_i));
          RegCruise: cruise = cfg_data_i[15:0];
          RegTarget: target = cfg_data_i[15:0];
          RegLook:   lookahead = cfg_data_i[15:0];
          RegWinLen: begin
            win_len = cfg_data_i[6:0];
            fill = 0; wptr = 0; err_sum = 0;
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (cmd_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result beat steer=%0d speed=%0d",
            $signed(steering_angle_i), drive_speed_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = cmd_q.pop_front();
          if (want.steer !== steering_angle_i || want.speed !== drive_speed_i) begin
            if (fail_count_o < 10)
              $display("mismatch: steer exp %0d got %0d, speed exp %0d got %0d",
                $signed(want.steer), $signed(steering_angle_i), want.speed, drive_speed_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_steering(range_side_i, range_ahead_i);
    end
  end

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import wfp_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [2:0]        cfg_idx_i;
  logic [GainW-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [RangeW-1:0] range_side_i;
  logic [RangeW-1:0] range_ahead_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [QW-1:0]     steering_angle_o;
  logic [RangeW-1:0] drive_speed_o;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;

  wall_follow_pid_steering dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .range_side_i, .range_ahead_i,
    .out_valid_o, .out_stall_i, .steering_angle_o, .drive_speed_o
  );

  wfp_steering_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .range_side_i, .range_ahead_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .steering_angle_i(steering_angle_o), .drive_speed_i(drive_speed_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: counts cycles with no beat on either side; the processing of a beat, the
  // random gap and stall and the settling pauses all end well inside its limit
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("wall_follow_pid_steering verification failed");
      $finish;
    end
  end

  // receiver: stall is held for a random extra delay before each result, sometimes none
  initial begin
    int hold;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      repeat (hold) @(negedge clk_i);
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
      out_stall_i <= 1'b1;
    end
  end

  // one input beat after a random gap (burst phases have no gap)
  task automatic send_ranges(input logic [15:0] side, input logic [15:0] ahead,
                             input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    repeat (gap) @(negedge clk_i);
    range_side_i <= side;
    range_ahead_i <= ahead;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // wait until all results are back, then let the pipeline settle
  task automatic drain;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // realistic range around a wall so the pid state does not pin at extremes
  function automatic logic [15:0] near_range();
    return 16'($urandom_range(200, 6000));
  endfunction

  initial begin
    logic [15:0] side, ahead;
    int kind;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegKp;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    range_side_i = '0;
    range_ahead_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings first, zero gains
    send_ranges(16'd0, 16'd0, 0);      // both ranges zero
    send_ranges(16'd0, 16'd1200, 0);   // side range zero, wall angle minus half pi
    send_ranges(16'd0, 16'hFFFF, 0);
    send_ranges(16'hFFFF, 16'd0, 0);
    send_ranges(16'hFFFF, 16'hFFFF, 0);
    drain();
    write_reg(RegKp, 32'h0100_0000);
    write_reg(RegKi, 32'h0001_0000);
    write_reg(RegKd, 32'h0080_0000);
    write_reg(RegCruise, 32'd2500);
    write_reg(RegTarget, 32'd1000);
    write_reg(RegLook, 32'd800);
    write_reg(RegWinLen, 32'd1);
    send_ranges(16'd1000, 16'd1414, 0);
    send_ranges(16'd1500, 16'd1800, 0);
    send_ranges(16'd800, 16'd900, 0);
    send_ranges(16'd1, 16'hFFFF, 0);
    send_ranges(16'hFFFF, 16'd1, 0);
    drain();
    // extremes of gains and zero/above-depth window lengths
    write_reg(RegKp, 32'h7FFF_FFFF);
    write_reg(RegKi, 32'h8000_0000);
    write_reg(RegKd, 32'h8000_0000);
    write_reg(RegCruise, 32'hFFFF);
    write_reg(RegTarget, 32'hFFFF);
    write_reg(RegLook, 32'hFFFF);
    write_reg(RegWinLen, 32'd0);
    send_ranges(16'd2000, 16'd2500, 0);
    send_ranges(16'd0, 16'd500, 0);
    send_ranges(16'hFFFF, 16'hFFFF, 0);
    drain();
    write_reg(RegWinLen, 32'd127);
    write_reg(RegTarget, 32'd0);
    write_reg(RegLook, 32'd0);
    send_ranges(16'd3000, 16'd100, 0);
    send_ranges(16'd100, 16'd3000, 0);
    send_ranges(16'd0, 16'd0, 0);

    // random phases: each with new settings, mostly small gains that keep the
    // steering inside the speed bands
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      if (phase == 5) begin
        write_reg(RegKp, $urandom());
        write_reg(RegKi, $urandom());
        write_reg(RegKd, $urandom());
      end else begin
        write_reg(RegKp, 32'($signed(32'($urandom_range(0, 32'h0400_0000)))
                             - 32'sh0200_0000));
        write_reg(RegKi, 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
        write_reg(RegKd, 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
      end
      write_reg(RegCruise, $urandom_range(0, 65535));
      write_reg(RegTarget, (phase == 0) ? 32'hFFFF : $urandom_range(300, 3000));
      write_reg(RegLook, (phase == 1) ? 32'hFFFF : $urandom_range(0, 2000));
      write_reg(RegWinLen, (phase == 2) ? 32'd64 : $urandom_range(1, 70));
      for (int n = 0; n < 100; n++) begin
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          side = 16'($urandom());
          ahead = 16'($urandom());
        end else if (kind == 1) begin
          side = 16'd0;
          ahead = ($urandom_range(0, 1) != 0) ? 16'($urandom()) : 16'd0;
        end else begin
          side = near_range();
          ahead = near_range();
        end
        send_ranges(side, ahead, phase == 3);
        // occasionally hold the sender until all results are in
        if (n == 50) while (pending != 0) @(negedge clk_i);
      end
    end

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("wall_follow_pid_steering verification clean");
    end else begin
      $display("wall_follow_pid_steering verification failed");
    end
    $finish;
  end

endmodule
